>>> src/sti_pkg.sv
package sti_pkg;

    localparam int ValueW = 32;
    localparam int OutW   = 5;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_ctl;

endpackage

>>> src/sti_cell.sv
module sti_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sti_pkg::t_ctl                   i_ctl,
    input  logic signed [sti_pkg::ValueW-1:0] i_cmp_key,
    input  logic signed [sti_pkg::ValueW-1:0] i_key,
    input  logic signed [sti_pkg::ValueW-1:0] i_left_data,
    input  logic                            i_left_valid,
    input  logic                            i_left_ge,
    input  logic signed [sti_pkg::ValueW-1:0] i_right_data,
    input  logic                            i_right_valid,
    output logic signed [sti_pkg::ValueW-1:0] o_data,
    output logic                            o_valid,
    output logic                            o_ge,
    output logic                            o_eq
);
    import sti_pkg::*;

    logic signed [ValueW-1:0] r_data;
    logic                     r_valid;
    logic                     r_ge;
    logic                     r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_ge <= !(r_valid && (r_data < i_cmp_key));
            r_eq <= (r_data == i_cmp_key);
        end
        if (i_ctl.ins && r_ge) begin
            r_data <= i_left_ge ? i_left_data : i_key;
        end else if (i_ctl.del && r_ge) begin
            r_data <= i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins && r_ge) begin
            r_valid <= i_left_ge ? i_left_valid : 1'b1;
        end else if (i_ctl.del && r_ge) begin
            r_valid <= i_right_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_ge    = r_ge;
    assign o_eq    = r_eq;

endmodule

>>> src/sorted_table_insert_delete.sv
// Sorted table, insert in order / delete first exact match.
// The compare is registered at accept; shift, count and result register on leaving S_UPD.
// A stalled result holds the shift and the input; no new item is taken while in S_UPD.
// All cells compare at accept; cells at or past the touched position shift away/toward it.
// Reset (synchronous, active low) empties the table and clears the result.
module sorted_table_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_action,
    input  logic signed [sti_pkg::ValueW-1:0] i_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_status,
    output logic [sti_pkg::OutW-1:0]         o_position,
    output logic [sti_pkg::OutW-1:0]         o_entry_count
);
    import sti_pkg::*;

    localparam int CntW = $clog2(CAPACITY + 1);

    t_state                   r_state;
    logic                     r_action;
    logic signed [ValueW-1:0] r_key;
    logic [CntW-1:0]          r_count;
    logic                     r_out_valid;
    t_status                  r_status;
    logic [CntW-1:0]          r_pos;

    logic signed [ValueW-1:0] cell_data  [CAPACITY];
    logic [CAPACITY-1:0]      cell_valid;
    logic [CAPACITY-1:0]      cell_ge;
    logic [CAPACITY-1:0]      cell_eq;
    logic [CAPACITY-1:0]      boundary;

    t_ctl            ctl;
    logic            accept;
    logic            leave;
    logic            full;
    logic            found;
    logic [CntW-1:0] hit_pos;
    logic [CntW-1:0] pos;
    t_status         n_status;
    logic [CntW-1:0] n_count;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign leave  = (r_state == S_UPD) && !(r_out_valid && i_out_stall);
    assign full   = (r_count == CntW'(CAPACITY));

    always_comb begin
        hit_pos = '0;
        found   = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            boundary[i] = cell_ge[i] && ((i == 0) ? 1'b1 : !cell_ge[(i == 0) ? 0 : i - 1]);
            if (boundary[i]) begin
                hit_pos = hit_pos | CntW'(i);
                found   = found | (cell_valid[i] && cell_eq[i]);
            end
        end
    end

    assign pos = (|boundary) ? hit_pos : r_count;

    assign ctl.cmp = accept;
    assign ctl.ins = leave && !r_action && !full;
    assign ctl.del = leave && r_action && found;

    always_comb begin
        n_count = r_count;
        if (!r_action) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_INSERTED;
                n_count  = r_count + CntW'(1);
            end
        end else if (found) begin
            n_status = ST_DELETED;
            n_count  = r_count - CntW'(1);
        end else begin
            n_status = ST_NOT_FOUND;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sti_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_cmp_key    (i_value),
            .i_key        (r_key),
            .i_left_data  ((g == 0) ? r_key : cell_data[(g == 0) ? 0 : g - 1]),
            .i_left_valid ((g == 0) ? 1'b0 : cell_valid[(g == 0) ? 0 : g - 1]),
            .i_left_ge    ((g == 0) ? 1'b0 : cell_ge[(g == 0) ? 0 : g - 1]),
            .i_right_data ((g == CAPACITY - 1) ? r_key
                           : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
            .i_right_valid((g == CAPACITY - 1) ? 1'b0
                           : cell_valid[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data       (cell_data[g]),
            .o_valid      (cell_valid[g]),
            .o_ge         (cell_ge[g]),
            .o_eq         (cell_eq[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_key    <= i_value;
        end
        if (leave) begin
            r_status <= n_status;
            r_pos    <= (n_status == ST_FULL || n_status == ST_NOT_FOUND) ? r_count : pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (leave) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (leave) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = OutW'(r_pos);
    assign o_entry_count = OutW'(r_count);

endmodule

>>> src/sti_checker.sv
module sti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [4:0]  o_position,
    input logic [4:0]  o_entry_count
);
    import sti_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    a_full_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_position == o_entry_count))
        else $error("full result position differs from count");

    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NOT_FOUND) |-> (o_position == o_entry_count))
        else $error("not-found result position differs from count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_position)
             && $stable(o_entry_count)))
        else $error("stalled result changed");

endmodule

bind sorted_table_insert_delete sti_checker u_sti_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_position   (o_position),
    .o_entry_count(o_entry_count)
);
